// ----- hw/rtl/cmt_pkg.sv -----
package cmt_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [CountW-1:0] RELOAD_COUNT = CountW'(1);
  localparam logic [CountW-1:0] RESET_COUNT  = CountW'(1);
  localparam logic [PeriodW-1:0] RESET_PERIOD = PeriodW'(1);

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_COUNT  = 3'd1,
    OP_ENABLE = 3'd2,
    OP_FLAG   = 3'd3,
    OP_IRQ_EN = 3'd4
  } cmt_op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPARE     = 2'd0,
    CFG_AUTO_RELOAD = 2'd1,
    CFG_NMI_MODE    = 2'd2,
    CFG_PERIOD      = 2'd3
  } cmt_cfg_idx_t;

  typedef struct packed {
    logic [CountW-1:0]  compare;
    logic               auto_reload;
    logic               nmi_mode;
    logic [PeriodW-1:0] period;
  } cmt_cfg_t;

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic               en;
    logic               flag;
    logic               irq_en;
    logic               irq;
    logic [PeriodW-1:0] presc;
  } cmt_state_t;

  typedef struct packed {
    cmt_state_t st;
    logic       nmi;
  } cmt_work_t;

  typedef struct packed {
    logic [CountW-1:0] count_now;
    logic              running;
    logic              status_flag;
    logic              interrupt_line;
    logic              nmi_request;
  } cmt_out_t;

  function automatic cmt_work_t cmt_write_flag(cmt_work_t w, cmt_cfg_t c, logic v);
    cmt_work_t r;
    r = w;
    if (w.st.flag && !v && !c.nmi_mode) begin
      if (w.st.count != c.compare) begin
        r.st.irq  = 1'b0;
        r.st.flag = v;
      end
    end else begin
      if (v && w.st.irq_en) begin
        if (c.nmi_mode) begin
          r.nmi = 1'b1;
        end else begin
          r.st.irq = 1'b1;
        end
      end
      r.st.flag = v;
    end
    return r;
  endfunction

  function automatic cmt_work_t cmt_time_out(cmt_work_t w, cmt_cfg_t c);
    cmt_work_t r;
    r = cmt_write_flag(w, c, 1'b1);
    if (!c.auto_reload) begin
      r.st.en = 1'b0;
    end else begin
      r.st.count = RELOAD_COUNT;
    end
    return r;
  endfunction

  function automatic cmt_work_t cmt_tick(cmt_work_t w, cmt_cfg_t c);
    cmt_work_t          r;
    logic [PeriodW-1:0] limit;
    logic [PeriodW:0]   nxt;
    r     = w;
    limit = (c.period == '0) ? PeriodW'(1) : c.period;
    nxt   = {1'b0, w.st.presc} + (PeriodW+1)'(1);
    if (w.st.en) begin
      if (nxt < {1'b0, limit}) begin
        r.st.presc = nxt[PeriodW-1:0];
      end else begin
        r.st.presc = '0;
        r.st.count = w.st.count + CountW'(1);
        if (r.st.count == c.compare) begin
          r = cmt_time_out(r, c);
        end
      end
    end
    return r;
  endfunction

  function automatic cmt_work_t cmt_write_enable(cmt_work_t w, cmt_cfg_t c, logic v);
    cmt_work_t r;
    r = w;
    if (!v) begin
      r.st.en = 1'b0;
    end else if (!w.st.en) begin
      r.st.en = 1'b1;
      if (c.compare == '0 && w.st.count == '0) begin
        r = cmt_time_out(r, c);
      end
      if (r.st.en) begin
        r.st.presc = '0;
        r = cmt_tick(r, c);
      end
    end
    return r;
  endfunction

  function automatic cmt_work_t cmt_write_irq_en(cmt_work_t w, cmt_cfg_t c, logic v);
    cmt_work_t r;
    r = w;
    if (!w.st.irq_en && v && !c.nmi_mode && w.st.flag) begin
      r.st.irq = 1'b1;
    end
    r.st.irq_en = v;
    return r;
  endfunction

endpackage

// ----- hw/rtl/cmt_if.sv -----
interface cmt_in_if;
  import cmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [CountW-1:0] write_value;

  modport source (output valid, output operation, output write_value, input ready);
  modport sink   (input valid, input operation, input write_value, output ready);
endinterface

interface cmt_out_if;
  import cmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] count_now;
  logic              running;
  logic              status_flag;
  logic              interrupt_line;
  logic              nmi_request;

  modport source (output valid, output count_now, output running, output status_flag,
                  output interrupt_line, output nmi_request, input ready);
  modport sink   (input valid, input count_now, input running, input status_flag,
                  input interrupt_line, input nmi_request, output ready);
endinterface

// ----- hw/rtl/compare_match_timer_channel_top.sv -----
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    operation[2:0], write_value[31:0]
// out_ch    out  valid/ready    count_now[31:0], running, status_flag,
//                               interrupt_line, nmi_request
// cfg_*     in   write enable   cfg_index[1:0], cfg_data[31:0]
//
// One word in, one word out; each result is registered; a new word every cycle while out_ch is not stalled.
// The whole step (prescale, increment, compare, timeout) sits between the
// channel state registers and the output register.
// in_ch.ready is high while the output register is empty or being taken.
// Reset is synchronous; it empties the output register and loads the
// reset values of state and configuration.
module compare_match_timer_channel_top (
  input  logic                   clk,
  input  logic                   rst_n,
  cmt_in_if.sink                 in_ch,
  cmt_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  cmt_pkg::cmt_cfg_idx_t  cfg_index,
  input  logic [cmt_pkg::CfgW-1:0] cfg_data
);
  import cmt_pkg::*;

  cmt_cfg_t   cfg_r;
  cmt_state_t state_r;
  cmt_out_t   out_r;
  logic       out_valid_r;
  logic       accept;
  cmt_work_t  w_cur;
  cmt_work_t  w_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compare     <= '0;
      cfg_r.auto_reload <= 1'b0;
      cfg_r.nmi_mode    <= 1'b0;
      cfg_r.period      <= RESET_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPARE:     cfg_r.compare     <= cfg_data[CountW-1:0];
        CFG_AUTO_RELOAD: cfg_r.auto_reload <= cfg_data[0];
        CFG_NMI_MODE:    cfg_r.nmi_mode    <= cfg_data[0];
        CFG_PERIOD:      cfg_r.period      <= cfg_data[PeriodW-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    w_cur.st  = state_r;
    w_cur.nmi = 1'b0;
    case (cmt_op_t'(in_ch.operation))
      OP_TICK:   w_nxt = cmt_tick(w_cur, cfg_r);
      OP_COUNT: begin
        w_nxt          = w_cur;
        w_nxt.st.count = in_ch.write_value;
      end
      OP_ENABLE: w_nxt = cmt_write_enable(w_cur, cfg_r, in_ch.write_value[0]);
      OP_FLAG:   w_nxt = cmt_write_flag(w_cur, cfg_r, in_ch.write_value[0]);
      OP_IRQ_EN: w_nxt = cmt_write_irq_en(w_cur, cfg_r, in_ch.write_value[0]);
      default:   w_nxt = w_cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.count  <= RESET_COUNT;
      state_r.en     <= 1'b0;
      state_r.flag   <= 1'b0;
      state_r.irq_en <= 1'b0;
      state_r.irq    <= 1'b0;
      state_r.presc  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= w_nxt.st;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.count_now      <= w_nxt.st.count;
      out_r.running        <= w_nxt.st.en;
      out_r.status_flag    <= w_nxt.st.flag;
      out_r.interrupt_line <= w_nxt.st.irq;
      out_r.nmi_request    <= w_nxt.nmi;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.count_now      = out_r.count_now;
  assign out_ch.running        = out_r.running;
  assign out_ch.status_flag    = out_r.status_flag;
  assign out_ch.interrupt_line = out_r.interrupt_line;
  assign out_ch.nmi_request    = out_r.nmi_request;

endmodule

// ----- hw/rtl/cmt_checker.sv -----
module cmt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cmt_pkg::CountW-1:0] count_now,
  input logic                       running,
  input logic                       status_flag
);
  import cmt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word gave no result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(count_now) && $stable(running)
      && $stable(status_flag))
    else $error("stalled result changed");

endmodule

bind compare_match_timer_channel_top cmt_checker u_cmt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .count_now   (out_ch.count_now),
  .running     (out_ch.running),
  .status_flag (out_ch.status_flag)
);
